[hw/rtl/nhcl_pkg.sv]
// ----------------------------------------------------------------------------
// nhcl_pkg: shared types and constants of the nibble handshake link
// Command codes, store geometry and the stage record passed from the
// handshake engine to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package nhcl_pkg;

  // Host command codes carried with each pin sample
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_FETCH = 3'd1;
  localparam logic [2:0] CMD_RECV  = 3'd2;
  localparam logic [2:0] CMD_SEND  = 3'd3;
  localparam logic [2:0] CMD_LOAD  = 3'd4;

  // Send length clamp and send store geometry
  localparam int unsigned SEND_DEPTH  = 64;
  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);

  localparam logic [7:0] SEND_CLAMP = 8'(SEND_DEPTH);

  // Engine results of one sample, as seen after that sample
  typedef struct packed {
    logic       sck_out;
    logic       sending;
    logic       busy;
    logic       len_pend;
    logic       low_next;
    logic [7:0] chunk_len;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic [7:0] rx_index;
    logic       rx_last;
    logic [7:0] rx_length;
    logic [1:0] cmd_value;
    logic       cmd_valid;
    logic       done;
  } stg_t;

endpackage

`default_nettype wire

[hw/rtl/nhcl_engine.sv]
// ----------------------------------------------------------------------------
// nhcl_engine: four-phase handshake engine with send store
// Advances the link state once per accepted pin sample, records the result
// of that sample and reads the send store byte that the next nibble needs.
// ----------------------------------------------------------------------------
`default_nettype none

module nhcl_engine (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         accept,
  input  wire logic [2:0]                   cmd,
  input  wire logic [nhcl_pkg::STORE_AW-1:0] load_index,
  input  wire logic [7:0]                   load_byte,
  input  wire logic [7:0]                   send_length,
  input  wire logic                         sck_in,
  input  wire logic [3:0]                   bus_in,
  input  wire logic [1:0]                   cmd_pins,
  output nhcl_pkg::stg_t                    stg,
  output logic [7:0]                        rd_byte
);
  import nhcl_pkg::*;

  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_FETCH = 2'd1,
    OP_RECV  = 2'd2,
    OP_SEND  = 2'd3
  } op_t;

  op_t        op_r, op_nxt, op_mid;
  logic [1:0] phase_r, phase_nxt;
  logic       low_next_r, low_next_nxt;
  logic [3:0] upper_r, upper_nxt;
  logic [7:0] count_r, count_nxt;
  logic [7:0] chunk_len_r, chunk_len_nxt;
  logic       len_pend_r, len_pend_nxt;
  logic       strobe_r, strobe_nxt;
  stg_t       stg_r, stg_nxt;

  logic [7:0] store_mem [STORE_DEPTH];
  logic [7:0] rd_byte_r;
  logic [STORE_AW-1:0] rd_addr;
  logic       wr_en;
  logic [7:0] rx_word;
  logic       done;

  assign rx_word = {upper_r, bus_in};
  assign wr_en   = accept && (cmd == CMD_LOAD);
  assign rd_addr = count_nxt[STORE_AW-1:0];

  // Advance the handshake for one pin sample
  always_comb begin
    op_nxt        = op_r;
    phase_nxt     = phase_r;
    low_next_nxt  = low_next_r;
    upper_nxt     = upper_r;
    count_nxt     = count_r;
    chunk_len_nxt = chunk_len_r;
    len_pend_nxt  = len_pend_r;
    strobe_nxt    = strobe_r;
    stg_nxt       = '0;
    done          = 1'b0;

    case (op_r)
      OP_IDLE: begin
        if (cmd inside {CMD_FETCH, CMD_RECV, CMD_SEND}) begin
          phase_nxt    = 2'd0;
          low_next_nxt = 1'b0;
          count_nxt    = 8'd0;
          len_pend_nxt = (cmd != CMD_FETCH);
          if (cmd == CMD_SEND) begin
            chunk_len_nxt = (send_length > SEND_CLAMP) ? SEND_CLAMP : send_length;
            strobe_nxt    = 1'b0;
            phase_nxt     = 2'd1;
            op_nxt        = OP_SEND;
          end else if (cmd == CMD_RECV) begin
            chunk_len_nxt = 8'd0;
            op_nxt        = OP_RECV;
          end else begin
            op_nxt = OP_FETCH;
          end
        end
      end
      OP_SEND: begin
        if (phase_r == 2'd1) begin
          // raise our strobe once the partner has taken the nibble
          if (!sck_in) begin
            strobe_nxt = 1'b1;
            phase_nxt  = 2'd2;
          end
        end else if (sck_in) begin
          // nibble finished: step to the next one
          if (!low_next_r) begin
            low_next_nxt = 1'b1;
          end else begin
            low_next_nxt = 1'b0;
            if (len_pend_r) len_pend_nxt = 1'b0;
            else            count_nxt    = count_r + 8'd1;
          end
          if (!len_pend_nxt && !low_next_nxt && (count_nxt >= chunk_len_r)) begin
            done = 1'b1;
          end else begin
            strobe_nxt = 1'b0;
            phase_nxt  = 2'd1;
          end
        end
      end
      default: begin
        if (phase_r == 2'd0) begin
          // partner strobe low: sample the pins and acknowledge
          if (!sck_in) begin
            strobe_nxt = 1'b0;
            phase_nxt  = 2'd1;
            if (op_r == OP_FETCH) begin
              stg_nxt.cmd_value = cmd_pins;
              stg_nxt.cmd_valid = 1'b1;
            end else if (!low_next_r) begin
              upper_nxt    = bus_in;
              low_next_nxt = 1'b1;
            end else begin
              low_next_nxt = 1'b0;
              if (len_pend_r) begin
                chunk_len_nxt = rx_word;
                len_pend_nxt  = 1'b0;
                count_nxt     = 8'd0;
              end else begin
                stg_nxt.rx_byte  = rx_word;
                stg_nxt.rx_valid = 1'b1;
                stg_nxt.rx_index = count_r;
                stg_nxt.rx_last  = ((count_r + 8'd1) == chunk_len_r);
                count_nxt        = count_r + 8'd1;
              end
            end
          end
        end else if (sck_in) begin
          // partner released: end the acknowledge
          strobe_nxt = 1'b1;
          phase_nxt  = 2'd0;
          if ((op_r == OP_FETCH) ||
              (!len_pend_r && !low_next_r && (count_r >= chunk_len_r))) begin
            done = 1'b1;
          end
        end
      end
    endcase

    op_mid = op_nxt;
    if (done) begin
      op_nxt    = OP_IDLE;
      phase_nxt = 2'd0;
    end

    stg_nxt.sck_out   = strobe_nxt;
    stg_nxt.sending   = (op_nxt == OP_SEND);
    stg_nxt.busy      = (op_nxt != OP_IDLE);
    stg_nxt.len_pend  = len_pend_nxt;
    stg_nxt.low_next  = low_next_nxt;
    stg_nxt.chunk_len = chunk_len_nxt;
    stg_nxt.rx_length = (op_mid == OP_RECV) ? chunk_len_nxt : 8'd0;
    stg_nxt.done      = done;
  end

  // Hold link state and the per-sample record
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r        <= OP_IDLE;
      phase_r     <= 2'd0;
      low_next_r  <= 1'b0;
      upper_r     <= 4'd0;
      count_r     <= 8'd0;
      chunk_len_r <= 8'd0;
      len_pend_r  <= 1'b0;
      strobe_r    <= 1'b1;
    end else if (accept) begin
      op_r        <= op_nxt;
      phase_r     <= phase_nxt;
      low_next_r  <= low_next_nxt;
      upper_r     <= upper_nxt;
      count_r     <= count_nxt;
      chunk_len_r <= chunk_len_nxt;
      len_pend_r  <= len_pend_nxt;
      strobe_r    <= strobe_nxt;
      stg_r       <= stg_nxt;
    end
  end

  // Send store: write on load, read the byte for the next nibble
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[load_index] <= load_byte;
    end
    if (accept) begin
      if (wr_en && (load_index == rd_addr)) rd_byte_r <= load_byte;
      else                                  rd_byte_r <= store_mem[rd_addr];
    end
  end

  assign stg     = stg_r;
  assign rd_byte = rd_byte_r;

endmodule

`default_nettype wire

[hw/rtl/nibble_handshake_chunk_link_top.sv]
// ----------------------------------------------------------------------------
// nibble_handshake_chunk_link_top: 4-bit parallel link pin engine
// Stream wrapper around the handshake engine with a registered result word.
// ----------------------------------------------------------------------------
// Each input word is one clock sample of the partner pins plus an optional
// host command; each one yields exactly one result word with the pin drive
// levels and any received byte or command. The block takes one word per
// clock while the output is not stalled; each result is registered in the
// handshake engine, whose send store read is registered, then in the output
// register. A stalled output holds the engine record and then input words.
`default_nettype none

module nibble_handshake_chunk_link_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // load_index[5:0], load_byte[13:6], send_length[21:14], sck_in[22],
  // bus_in[26:23], cmd_pins[28:27], zero fill[31:29]
  input  wire logic [31:0] in_tdata,
  // cmd[2:0]
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // sck_out[0], bus_out[4:1], bus_drive[5], busy_res[6], rx_byte[14:7],
  // rx_valid[15], rx_index[23:16], rx_length[31:24], command_value[33:32],
  // command_valid[34], done_res[35], zero fill[39:36]
  output logic [39:0]      out_tdata,
  // rx_last
  output logic             out_tlast
);
  import nhcl_pkg::*;

  stg_t       stg;
  logic [7:0] rd_byte;
  logic       accept;
  logic       s1_valid_r, s1_valid_nxt;
  logic       out_load;
  logic       out_valid_r;
  logic [39:0] out_data_r, out_data_nxt;
  logic       out_last_r;
  logic [7:0] nib_src;
  logic [3:0] nib;

  assign out_load  = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || out_load;
  assign accept    = in_tvalid && in_tready;

  nhcl_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .cmd         (in_tuser),
    .load_index  (in_tdata[5:0]),
    .load_byte   (in_tdata[13:6]),
    .send_length (in_tdata[21:14]),
    .sck_in      (in_tdata[22]),
    .bus_in      (in_tdata[26:23]),
    .cmd_pins    (in_tdata[28:27]),
    .stg         (stg),
    .rd_byte     (rd_byte)
  );

  // Pick the nibble to drive: length byte first, then store bytes
  assign nib_src = stg.len_pend ? stg.chunk_len : rd_byte;
  assign nib     = stg.low_next ? nib_src[3:0] : nib_src[7:4];

  // Pack the result word
  always_comb begin
    out_data_nxt        = '0;
    out_data_nxt[0]     = stg.sck_out;
    out_data_nxt[4:1]   = stg.sending ? nib : 4'd0;
    out_data_nxt[5]     = stg.sending;
    out_data_nxt[6]     = stg.busy;
    out_data_nxt[14:7]  = stg.rx_byte;
    out_data_nxt[15]    = stg.rx_valid;
    out_data_nxt[23:16] = stg.rx_index;
    out_data_nxt[31:24] = stg.rx_length;
    out_data_nxt[33:32] = stg.cmd_value;
    out_data_nxt[34]    = stg.cmd_valid;
    out_data_nxt[35]    = stg.done;
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept)        s1_valid_nxt = 1'b1;
    else if (out_load) s1_valid_nxt = 1'b0;
  end

  // Advance the engine stage and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_data_r  <= out_data_nxt;
        out_last_r  <= stg.rx_last;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // Bus is only driven while a send is in progress
  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[5] |-> out_data_r[6])
    else $error("bus driven while link idle");

  // A sample never completes both a data byte and a command read
  a_rx_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r[15] && out_data_r[34]))
    else $error("byte and command reported on one sample");

  // Last marker only rides on a received byte
  a_last_rx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_data_r[15])
    else $error("tlast without received byte");

  // A finished operation leaves the link idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[35] |-> !out_data_r[6] && out_data_r[0])
    else $error("done with link still busy or strobe low");

endmodule

`default_nettype wire
